/* sv/txrcd_pkg.sv */
// txrcd_pkg: shared types and constants of the transmit ring chunk dispatcher
// no dependencies; used by txrcd_kick and tx_ring_chunk_dispatcher_core
`default_nettype none

package txrcd_pkg;

  // ring size and timeout register reset value
  localparam int unsigned BufDepthDefault = 512;
  localparam logic [15:0] TimeoutReset    = 16'd100;

  // item opcodes
  typedef enum logic [1:0] {
    ActBegin = 2'd0,
    ActByte  = 2'd1,
    ActPoll  = 2'd2,
    ActRead  = 2'd3
  } action_e;

  // status of one kick
  typedef struct packed {
    logic aborted;
    logic started;
  } kick_flags_t;

endpackage

`default_nettype wire

/* sv/tx_ring_chunk_dispatcher_core.sv */
// tx_ring_chunk_dispatcher_core: transmit ring that hands contiguous chunks to a dma engine
// depends on txrcd_pkg, txrcd_kick and txrcd_ring_mem
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one item: begin write, write byte,
//   poll kick or read byte, with link and dma status and the millisecond tick.
//   output channel (out_valid_o / out_ready_i) returns exactly one result item per
//   input item, in order.
//   cfg_we_i / cfg_wdata_i write the stuck timeout (ms); write only while idle.
// result timing and throughput:
//   the result is registered and appears in the cycle after the item is accepted; one item
//   per cycle is sustained while out_ready_i stays high. the rate is set by the state update
//   loop (head, pending, in-flight, fill pointer), updated combinationally, and by the single
//   write and read port of the byte store, which each item uses at most once.
// stall:
//   a result waiting in the output register does not block input as long as the
//   receiver takes it in the same cycle; when the receiver holds out_ready_i low the
//   input ready drops until the result is taken.
// reset:
//   pointers and counts clear, no write is open, the timeout returns to 100 ms.
//   the byte store is not cleared; a read of a never-written position is undefined.
`default_nettype none

module tx_ring_chunk_dispatcher_core #(
  parameter int unsigned BufDepth = txrcd_pkg::BufDepthDefault,
  parameter int unsigned PtrW     = $clog2(BufDepth),
  parameter int unsigned CntW     = PtrW + 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  // input channel
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      action_i,
  input  wire logic [15:0]     write_length_i,
  input  wire logic [7:0]      byte_data_i,
  input  wire logic [PtrW-1:0] read_index_i,
  input  wire logic            link_ready_i,
  input  wire logic            dma_accepts_i,
  input  wire logic [31:0]     now_ms_i,
  // output channel
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 accepted_o,
  output logic                 tx_error_o,
  output logic                 aborted_o,
  output logic                 chunk_started_o,
  output logic      [PtrW-1:0] chunk_start_o,
  output logic      [CntW-1:0] chunk_length_o,
  output logic      [7:0]      read_data_o,
  output logic      [CntW-1:0] pending_count_o
);

  localparam logic [CntW-1:0] DepthC  = CntW'(BufDepth);
  localparam logic [PtrW-1:0] LastPos = PtrW'(BufDepth - 1);

  // ring state
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] pending_q, pending_d;
  logic [CntW-1:0] inflight_q, inflight_d;
  logic [31:0]     start_time_q, start_time_d;
  logic [PtrW-1:0] fill_q, fill_d;
  logic [CntW-1:0] left_q, left_d;
  logic [CntW-1:0] open_len_q, open_len_d;
  logic [15:0]     timeout_q;

  // result register
  logic            out_valid_q, out_valid_d;
  logic            accepted_q, accepted_d;
  logic            tx_error_q, tx_error_d;
  logic            aborted_q, aborted_d;
  logic            started_q, started_d;
  logic [PtrW-1:0] chunk_start_q, chunk_start_d;
  logic [CntW-1:0] chunk_len_q, chunk_len_d;
  logic [CntW-1:0] pend_cnt_q;
  logic            is_read_q, is_read_d;

  // datapath
  logic                   accept;
  logic                   valid_len;
  logic                   last_byte;
  logic [CntW:0]          commit_sum;
  logic [CntW-1:0]        commit_pend;
  logic [CntW-1:0]        kick_pend_in;
  logic                   kick_run;
  logic [PtrW-1:0]        k_head;
  logic [CntW-1:0]        k_pend;
  logic [CntW-1:0]        k_infl;
  logic [31:0]            k_time;
  logic [CntW-1:0]        k_clen;
  txrcd_pkg::kick_flags_t k_flags;
  logic [CntW-1:0]        fill_sum;
  logic [PtrW-1:0]        fill_new;
  logic                   no_space;
  logic                   mem_we;
  logic                   mem_re;
  logic [PtrW:0]          ridx_ext;
  logic [PtrW-1:0]        ridx;
  logic [7:0]             mem_rdata;

  // input is taken whenever the result register is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign valid_len = (write_length_i != 16'd0) && (write_length_i <= 16'(BufDepth));
  assign last_byte = (left_q == CntW'(1));

  // committing the open message, saturated at the ring size
  assign commit_sum  = (CntW+1)'(pending_q) + (CntW+1)'(open_len_q);
  assign commit_pend = (commit_sum > (CntW+1)'(BufDepth)) ? DepthC : CntW'(commit_sum);

  // byte items kick with the freshly committed count
  assign kick_pend_in = (txrcd_pkg::action_e'(action_i) == txrcd_pkg::ActByte)
                        ? commit_pend : pending_q;

  txrcd_kick #(
    .BufDepth (BufDepth),
    .PtrW     (PtrW),
    .CntW     (CntW)
  ) u_kick (
    .ready_i      (link_ready_i),
    .dma_ok_i     (dma_accepts_i),
    .now_i        (now_ms_i),
    .timeout_i    (timeout_q),
    .head_i       (head_q),
    .pending_i    (kick_pend_in),
    .inflight_i   (inflight_q),
    .start_time_i (start_time_q),
    .head_o       (k_head),
    .pending_o    (k_pend),
    .inflight_o   (k_infl),
    .start_time_o (k_time),
    .chunk_len_o  (k_clen),
    .flags_o      (k_flags)
  );

  // tail of the ring after the kick of a begin write
  assign fill_sum = CntW'(k_head) + k_pend;
  assign fill_new = (fill_sum >= DepthC) ? PtrW'(fill_sum - DepthC) : PtrW'(fill_sum);
  assign no_space = 16'(DepthC - k_pend) < write_length_i;

  // read position taken modulo the ring size
  assign ridx_ext = {1'b0, read_index_i};
  assign ridx     = (ridx_ext >= (PtrW+1)'(BufDepth))
                    ? PtrW'(ridx_ext - (PtrW+1)'(BufDepth)) : read_index_i;

  always_comb begin
    head_d       = head_q;
    pending_d    = pending_q;
    inflight_d   = inflight_q;
    start_time_d = start_time_q;
    fill_d       = fill_q;
    left_d       = left_q;
    open_len_d   = open_len_q;
    kick_run     = 1'b0;
    accepted_d   = 1'b0;
    tx_error_d   = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    is_read_d    = 1'b0;

    case (txrcd_pkg::action_e'(action_i))
      txrcd_pkg::ActBegin: begin
        // bad lengths are dropped with no kick
        if (valid_len) begin
          kick_run = 1'b1;
          if (no_space) begin
            tx_error_d = 1'b1;
          end else begin
            fill_d     = fill_new;
            left_d     = CntW'(write_length_i);
            open_len_d = CntW'(write_length_i);
            accepted_d = 1'b1;
          end
        end
      end
      txrcd_pkg::ActByte: begin
        // stray bytes with no open write are ignored
        if (left_q != '0) begin
          mem_we = 1'b1;
          fill_d = (fill_q == LastPos) ? '0 : fill_q + PtrW'(1);
          left_d = left_q - CntW'(1);
          if (last_byte) begin
            pending_d  = commit_pend;
            open_len_d = '0;
            kick_run   = 1'b1;
          end
        end
      end
      txrcd_pkg::ActPoll: begin
        kick_run = 1'b1;
      end
      txrcd_pkg::ActRead: begin
        mem_re    = 1'b1;
        is_read_d = 1'b1;
      end
      default: begin
        kick_run = 1'b0;
      end
    endcase

    if (kick_run) begin
      head_d       = k_head;
      pending_d    = k_pend;
      inflight_d   = k_infl;
      start_time_d = k_time;
    end

    aborted_d     = kick_run && k_flags.aborted;
    started_d     = kick_run && k_flags.started;
    tx_error_d    = tx_error_d || aborted_d;
    chunk_start_d = started_d ? k_head : '0;
    chunk_len_d   = started_d ? k_clen : '0;
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  txrcd_ring_mem #(
    .Depth (BufDepth),
    .AddrW (PtrW)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (accept && mem_we),
    .waddr_i (fill_q),
    .wdata_i (byte_data_i),
    .re_i    (accept && mem_re),
    .raddr_i (ridx),
    .rdata_o (mem_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      pending_q    <= '0;
      inflight_q   <= '0;
      start_time_q <= '0;
      fill_q       <= '0;
      left_q       <= '0;
      open_len_q   <= '0;
      timeout_q    <= txrcd_pkg::TimeoutReset;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (accept) begin
        head_q       <= head_d;
        pending_q    <= pending_d;
        inflight_q   <= inflight_d;
        start_time_q <= start_time_d;
        fill_q       <= fill_d;
        left_q       <= left_d;
        open_len_q   <= open_len_d;
      end
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      accepted_q    <= accepted_d;
      tx_error_q    <= tx_error_d;
      aborted_q     <= aborted_d;
      started_q     <= started_d;
      chunk_start_q <= chunk_start_d;
      chunk_len_q   <= chunk_len_d;
      pend_cnt_q    <= pending_d;
      is_read_q     <= is_read_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign tx_error_o      = tx_error_q;
  assign aborted_o       = aborted_q;
  assign chunk_started_o = started_q;
  assign chunk_start_o   = chunk_start_q;
  assign chunk_length_o  = chunk_len_q;
  assign read_data_o     = is_read_q ? mem_rdata : 8'd0;
  assign pending_count_o = pend_cnt_q;

`ifndef SYNTH
  // in-flight bytes are always part of the pending count, which never exceeds the ring
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q <= pending_q) && (pending_q <= DepthC))
    else $error("pending or in-flight count out of range");

  // a launched chunk is non-empty and stays inside the ring
  a_chunk_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_started_o) |->
      ((chunk_length_o != '0) &&
       ((CntW+1)'(chunk_start_o) + (CntW+1)'(chunk_length_o) <= (CntW+1)'(BufDepth))))
    else $error("launched chunk empty or crossing the ring end");

  // a dropped chunk always raises the error flag and launches nothing
  a_abort_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && aborted_o) |-> (tx_error_o && !chunk_started_o))
    else $error("abort without error flag or with a launch");

  // an open write never wants more bytes than its message holds
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= open_len_q)
    else $error("bytes left exceed open message length");
`endif

endmodule

`default_nettype wire

/* sv/txrcd_ring_mem.sv */
// txrcd_ring_mem: byte store of the transmit ring, one write and one registered read port
// no package dependencies
`default_nettype none

module txrcd_ring_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // no reset: entries are undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/txrcd_kick.sv */
// txrcd_kick: combinational kick step (stuck abort, reclaim, launch of next chunk)
// depends on txrcd_pkg for kick_flags_t
`default_nettype none

module txrcd_kick #(
  parameter int unsigned BufDepth = txrcd_pkg::BufDepthDefault,
  parameter int unsigned PtrW     = $clog2(BufDepth),
  parameter int unsigned CntW     = PtrW + 1
) (
  input  wire logic                   ready_i,
  input  wire logic                   dma_ok_i,
  input  wire logic [31:0]            now_i,
  input  wire logic [15:0]            timeout_i,
  input  wire logic [PtrW-1:0]        head_i,
  input  wire logic [CntW-1:0]        pending_i,
  input  wire logic [CntW-1:0]        inflight_i,
  input  wire logic [31:0]            start_time_i,
  output logic      [PtrW-1:0]        head_o,
  output logic      [CntW-1:0]        pending_o,
  output logic      [CntW-1:0]        inflight_o,
  output logic      [31:0]            start_time_o,
  output logic      [CntW-1:0]        chunk_len_o,
  output txrcd_pkg::kick_flags_t      flags_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(BufDepth);

  logic [CntW-1:0] head_sum;
  logic [PtrW-1:0] rc_head;
  logic [CntW-1:0] rc_pend;
  logic [CntW-1:0] room;
  logic [CntW-1:0] chunk;
  logic [31:0]     elapsed;
  logic            stuck;

  // finished or aborted chunk moves the head past it, wrapping once at most
  assign head_sum = CntW'(head_i) + inflight_i;
  assign rc_head  = (head_sum >= DepthC) ? PtrW'(head_sum - DepthC) : PtrW'(head_sum);
  assign rc_pend  = pending_i - inflight_i;

  // next chunk runs to the end of the ring at most
  assign room  = DepthC - CntW'(rc_head);
  assign chunk = (room > rc_pend) ? rc_pend : room;

  // wrapping tick difference
  assign elapsed = now_i - start_time_i;
  assign stuck   = (inflight_i != '0) && (elapsed > 32'(timeout_i));

  always_comb begin
    head_o          = head_i;
    pending_o       = pending_i;
    inflight_o      = inflight_i;
    start_time_o    = start_time_i;
    chunk_len_o     = '0;
    flags_o.aborted = 1'b0;
    flags_o.started = 1'b0;
    if (!ready_i) begin
      if (stuck) begin
        head_o          = rc_head;
        pending_o       = rc_pend;
        inflight_o      = '0;
        flags_o.aborted = 1'b1;
      end
    end else begin
      head_o     = rc_head;
      pending_o  = rc_pend;
      inflight_o = '0;
      if ((rc_pend != '0) && dma_ok_i) begin
        inflight_o      = chunk;
        start_time_o    = now_i;
        chunk_len_o     = chunk;
        flags_o.started = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* verif/txrcd_ring_checker.sv */
// txrcd_ring_checker: follows the ring, pointers and stuck timeout from observed items and
// compares every result item with its prediction
// depends on txrcd_pkg
module txrcd_ring_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [1:0]   action_i,
  input  logic [15:0]  write_length_i,
  input  logic [7:0]   byte_data_i,
  input  logic [8:0]   read_index_i,
  input  logic         link_ready_i,
  input  logic         dma_accepts_i,
  input  logic [31:0]  now_ms_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic         accepted_i,
  input  logic         tx_error_i,
  input  logic         aborted_i,
  input  logic         chunk_started_i,
  input  logic [8:0]   chunk_start_i,
  input  logic [9:0]   chunk_length_i,
  input  logic [7:0]   read_data_i,
  input  logic [9:0]   pending_count_i,
  output int unsigned  mismatch_count_o,
  output int unsigned  results_owed_o,
  output logic [511:0] stored_mask_o
);
  import txrcd_pkg::*;

  localparam int unsigned RingDepth = BufDepthDefault;

  typedef struct packed {
    logic       accepted;
    logic       tx_error;
    logic       aborted;
    logic       started;
    logic [8:0] start_pos;
    logic [9:0] length;
    logic [7:0] rdata;
    logic [9:0] pending;
  } tx_result_t;

  logic [7:0]  ring_bytes [RingDepth];
  logic [8:0]  head_pos;
  logic [9:0]  pend_cnt;
  logic [9:0]  flight_cnt;
  logic [31:0] launch_ms;
  logic [8:0]  tail_pos;
  logic [9:0]  fill_left;
  logic [9:0]  msg_len;
  logic [15:0] timeout_ms;

  tx_result_t owed_q [$];
  tx_result_t want_r;
  tx_result_t next_r;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // chunk done or dropped: its bytes leave the ring
  task automatic retire_flight();
    head_pos   = 9'((head_pos + flight_cnt) % RingDepth);
    pend_cnt   = pend_cnt - flight_cnt;
    flight_cnt = '0;
  endtask

  task automatic kick_ring(inout tx_result_t r);
    logic [31:0] age;
    int unsigned span;
    age = now_ms_i - launch_ms;
    if (!link_ready_i) begin
      if (flight_cnt != 0 && age > {16'd0, timeout_ms}) begin
        retire_flight();
        r.tx_error = 1'b1;
        r.aborted  = 1'b1;
      end
    end else begin
      if (flight_cnt != 0) retire_flight();
      if (pend_cnt != 0) begin
        // contiguous run, stops at the end of the ring
        span = RingDepth - head_pos;
        if (span > pend_cnt) span = pend_cnt;
        if (dma_accepts_i) begin
          flight_cnt  = 10'(span);
          launch_ms   = now_ms_i;
          r.started   = 1'b1;
          r.start_pos = head_pos;
          r.length    = 10'(span);
        end
      end
    end
  endtask

  task automatic dispatch_item(output tx_result_t r);
    int unsigned total;
    r = '0;
    case (action_e'(action_i))
      ActBegin: begin
        if (write_length_i != 16'd0 && write_length_i <= RingDepth) begin
          kick_ring(r);
          if (RingDepth - pend_cnt < write_length_i) begin
            r.tx_error = 1'b1;
          end else begin
            tail_pos   = 9'((head_pos + pend_cnt) % RingDepth);
            fill_left  = write_length_i[9:0];
            msg_len    = write_length_i[9:0];
            r.accepted = 1'b1;
          end
        end
      end
      ActByte: begin
        if (fill_left != 0) begin
          ring_bytes[tail_pos]    = byte_data_i;
          stored_mask_o[tail_pos] = 1'b1;
          tail_pos  = tail_pos + 9'd1;
          fill_left = fill_left - 10'd1;
          if (fill_left == 0) begin
            total    = pend_cnt + msg_len;
            pend_cnt = (total > RingDepth) ? 10'(RingDepth) : 10'(total);
            msg_len  = '0;
            kick_ring(r);
          end
        end
      end
      ActPoll: kick_ring(r);
      default: r.rdata = ring_bytes[read_index_i];
    endcase
    r.pending = pend_cnt;
  endtask

  // results are checked before the item of the same edge is taken in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos       = '0;
      pend_cnt       = '0;
      flight_cnt     = '0;
      launch_ms      = '0;
      tail_pos       = '0;
      fill_left      = '0;
      msg_len        = '0;
      timeout_ms     = TimeoutReset;
      stored_mask_o  = '0;
      owed_q.delete();
      results_owed_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("result item with no item outstanding");
          mismatch_count_o++;
        end else begin
          want_r = owed_q.pop_front();
          check_field("accepted", want_r.accepted, accepted_i);
          check_field("tx_error", want_r.tx_error, tx_error_i);
          check_field("aborted", want_r.aborted, aborted_i);
          check_field("chunk_started", want_r.started, chunk_started_i);
          check_field("chunk_start", want_r.start_pos, chunk_start_i);
          check_field("chunk_length", want_r.length, chunk_length_i);
          check_field("read_data", want_r.rdata, read_data_i);
          check_field("pending_count", want_r.pending, pending_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        dispatch_item(next_r);
        owed_q.push_back(next_r);
      end
      if (cfg_we_i) timeout_ms = cfg_wdata_i;
      results_owed_o = owed_q.size();
    end
  end

endmodule

/* verif/tb_tx_ring_chunk_dispatcher_core.sv */
// tb_tx_ring_chunk_dispatcher_core: drives begin, byte, poll and read items with random link,
// dma and tick status into the ring, paces both channels and gives the verdict
// depends on txrcd_pkg, tx_ring_chunk_dispatcher_core and txrcd_ring_checker
module tb_tx_ring_chunk_dispatcher_core;
  import txrcd_pkg::*;

  localparam int unsigned RingDepth = BufDepthDefault;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         in_valid_i;
  logic         in_ready_o;
  logic [1:0]   action_i;
  logic [15:0]  write_length_i;
  logic [7:0]   byte_data_i;
  logic [8:0]   read_index_i;
  logic         link_ready_i;
  logic         dma_accepts_i;
  logic [31:0]  now_ms_i;
  logic         out_valid_o;
  logic         out_ready_i;
  logic         accepted_o;
  logic         tx_error_o;
  logic         aborted_o;
  logic         chunk_started_o;
  logic [8:0]   chunk_start_o;
  logic [9:0]   chunk_length_o;
  logic [7:0]   read_data_o;
  logic [9:0]   pending_count_o;

  int unsigned  mismatch_count;
  int unsigned  results_owed;
  logic [511:0] stored_mask;

  // pacing knobs, percent of cycles spent idle, and percent of items with link ready or dma accepting
  int unsigned  tx_gap_pct;
  int unsigned  rx_stall_pct;
  int unsigned  link_pct;
  int unsigned  dma_pct;

  // long receiver hold-off, requested by the stimulus, counted by the receiver
  int unsigned  hold_asks = 0;
  int unsigned  hold_served = 0;
  int unsigned  hold_left = 0;

  // running millisecond tick for random items
  logic [31:0]  tick_ms;

  tx_ring_chunk_dispatcher_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .write_length_i (write_length_i),
    .byte_data_i    (byte_data_i),
    .read_index_i   (read_index_i),
    .link_ready_i   (link_ready_i),
    .dma_accepts_i  (dma_accepts_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .tx_error_o     (tx_error_o),
    .aborted_o      (aborted_o),
    .chunk_started_o(chunk_started_o),
    .chunk_start_o  (chunk_start_o),
    .chunk_length_o (chunk_length_o),
    .read_data_o    (read_data_o),
    .pending_count_o(pending_count_o)
  );

  txrcd_ring_checker ring_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .write_length_i  (write_length_i),
    .byte_data_i     (byte_data_i),
    .read_index_i    (read_index_i),
    .link_ready_i    (link_ready_i),
    .dma_accepts_i   (dma_accepts_i),
    .now_ms_i        (now_ms_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_i      (accepted_o),
    .tx_error_i      (tx_error_o),
    .aborted_i       (aborted_o),
    .chunk_started_i (chunk_started_o),
    .chunk_start_i   (chunk_start_o),
    .chunk_length_i  (chunk_length_o),
    .read_data_i     (read_data_o),
    .pending_count_i (pending_count_o),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed),
    .stored_mask_o   (stored_mask)
  );

  // 12 unit clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = 48;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // first written position at or after the hint, so no read hits an unwritten byte
  function automatic logic [8:0] stored_index(input logic [8:0] hint);
    logic [8:0] idx;
    for (int i = 0; i < RingDepth; i++) begin
      idx = hint + 9'(i);
      if (stored_mask[idx]) return idx;
    end
    return hint;
  endfunction

  // offer one item and hold it until it is accepted; valid stays high on return
  task automatic send_item(input action_e act, input logic [15:0] len, input logic [7:0] data,
                           input logic [8:0] ridx, input logic ready, input logic dma_ok,
                           input logic [31:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    // mask is read at the falling edge, after the checker has taken earlier items
    if (act == ActRead) begin
      if (stored_mask == '0) act = ActPoll;
      else ridx = stored_index(ridx);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    write_length_i <= len;
    byte_data_i    <= data;
    read_index_i   <= ridx;
    link_ready_i   <= ready;
    dma_accepts_i  <= dma_ok;
    now_ms_i       <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // same, with random link and dma status and a mostly advancing tick
  task automatic send_live(input action_e act, input logic [15:0] len, input logic [7:0] data,
                           input logic [8:0] ridx);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll == 0) tick_ms = $urandom();
    else if (roll < 4) tick_ms = tick_ms + $urandom_range(200000, 1000);
    else tick_ms = tick_ms + $urandom_range(25, 0);
    send_item(act, len, data, ridx, $urandom_range(99) < link_pct,
              $urandom_range(99) < dma_pct, tick_ms);
  endtask

  // stop offering and wait until every result item has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_timeout(input logic [15:0] ms);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // hand-picked items, timeout at its reset value of 100 ms
  task automatic run_directed();
    // lengths the ring refuses without a kick
    send_item(ActBegin, 16'd0,    8'h00, 9'd0,   1'b1, 1'b1, 32'h0000_0000);
    send_item(ActBegin, 16'd513,  8'h00, 9'd0,   1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(ActBegin, 16'hFFFF, 8'hFF, 9'h1FF, 1'b0, 1'b0, 32'hFFFF_FFF0);
    // byte with no write open
    send_item(ActByte,  16'd0,    8'hFF, 9'd0,   1'b1, 1'b1, 32'hFFFF_FFF0);
    // three byte message, launched on its last byte
    send_item(ActBegin, 16'd3,    8'h00, 9'd0,   1'b1, 1'b1, 32'hFFFF_FFF0);
    send_item(ActByte,  16'd0,    8'h00, 9'd0,   1'b1, 1'b0, 32'hFFFF_FFF2);
    send_item(ActByte,  16'd0,    8'hFF, 9'd0,   1'b0, 1'b1, 32'hFFFF_FFF4);
    send_item(ActByte,  16'd0,    8'hA5, 9'd0,   1'b1, 1'b1, 32'hFFFF_FFF8);
    send_item(ActRead,  16'd0,    8'h00, 9'd1,   1'b1, 1'b1, 32'hFFFF_FFF9);
    // busy for 104 ms across the tick wrap: stuck chunk dropped
    send_item(ActPoll,  16'd0,    8'h00, 9'd0,   1'b0, 1'b1, 32'h0000_0060);
    send_item(ActPoll,  16'd0,    8'h00, 9'd0,   1'b0, 1'b1, 32'h0000_0061);
    // commit while the link is busy, nothing launches
    send_item(ActBegin, 16'd3,    8'h00, 9'd0,   1'b0, 1'b1, 32'h0000_0062);
    send_item(ActByte,  16'd0,    8'h5A, 9'd0,   1'b0, 1'b1, 32'h0000_0063);
    send_item(ActByte,  16'd0,    8'h3C, 9'd0,   1'b0, 1'b1, 32'h0000_0064);
    send_item(ActByte,  16'd0,    8'hC3, 9'd0,   1'b0, 1'b1, 32'h0000_0065);
    // open a write, then a full-ring begin that finds no room
    send_item(ActBegin, 16'd2,    8'h00, 9'd0,   1'b0, 1'b0, 32'h0000_0070);
    send_item(ActBegin, 16'd512,  8'h00, 9'd0,   1'b0, 1'b0, 32'h0000_0071);
    send_item(ActByte,  16'd0,    8'h11, 9'd0,   1'b0, 1'b0, 32'h0000_0072);
    // a new begin replaces the open write
    send_item(ActBegin, 16'd1,    8'h00, 9'd0,   1'b0, 1'b0, 32'h0000_0073);
    send_item(ActByte,  16'd0,    8'h22, 9'd0,   1'b1, 1'b0, 32'h0000_0074);
    send_item(ActPoll,  16'd0,    8'h00, 9'd0,   1'b1, 1'b1, 32'h0000_0075);
    // reclaim empties the ring, so the full length now fits
    send_item(ActBegin, 16'd512,  8'h00, 9'd0,   1'b1, 1'b1, 32'h0000_0080);
    send_item(ActBegin, 16'd5,    8'h00, 9'd0,   1'b1, 1'b1, 32'h0000_0081);
    send_item(ActRead,  16'd0,    8'h00, 9'd6,   1'b1, 1'b1, 32'h0000_0082);
    tick_ms = 32'h0000_0090;
  endtask

  // mostly whole messages with random content, some polls and reads, a little noise
  task automatic run_traffic(input int unsigned n_items);
    int unsigned done_items;
    int unsigned pick;
    int unsigned msg_len;
    int unsigned fill_cnt;
    int unsigned bad_len;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        msg_len = ($urandom_range(19) == 0) ? $urandom_range(220, 64) : $urandom_range(32, 1);
        fill_cnt = msg_len;
        // full-ring length: usually refused, otherwise left unfinished
        if ($urandom_range(49) == 0) begin
          msg_len  = RingDepth;
          fill_cnt = $urandom_range(60, 1);
        end else if ($urandom_range(29) == 0) begin
          fill_cnt = $urandom_range(msg_len - 1, 0);
        end
        send_live(ActBegin, 16'(msg_len), 8'(0), 9'(0));
        done_items++;
        for (int k = 0; k < fill_cnt; k++) begin
          if ($urandom_range(99) < 4) begin
            send_live(ActPoll, 16'(0), 8'(0), 9'(0));
            done_items++;
          end
          send_live(ActByte, 16'(0), 8'($urandom_range(255)), 9'(0));
          done_items++;
        end
      end else if (pick < 80) begin
        send_live(ActPoll, 16'(0), 8'(0), 9'(0));
        done_items++;
      end else if (pick < 90) begin
        send_live(ActRead, 16'(0), 8'(0), 9'($urandom_range(RingDepth - 1)));
        done_items++;
      end else if (pick < 95) begin
        // ignored lengths, not counted
        bad_len = $urandom_range(1) ? $urandom_range(65535, RingDepth + 1) : 0;
        send_live(ActBegin, 16'(bad_len), 8'($urandom_range(255)), 9'(0));
      end else begin
        send_live(ActByte, 16'(0), 8'($urandom_range(255)), 9'(0));
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    action_i       = ActPoll;
    write_length_i = '0;
    byte_data_i    = '0;
    read_index_i   = '0;
    link_ready_i   = 1'b0;
    dma_accepts_i  = 1'b0;
    now_ms_i       = '0;
    out_ready_i    = 1'b0;
    tick_ms        = '0;
    link_pct       = 70;
    dma_pct        = 75;
    tx_gap_pct     = 9;
    rx_stall_pct   = 60;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    // sender mostly busy, receiver often stalls; zero timeout drops a busy chunk once the tick moves
    set_timeout(16'd0);
    run_traffic(240);

    // sender often idle, receiver mostly ready; longest timeout
    set_timeout(16'hFFFF);
    tx_gap_pct   = 60;
    rx_stall_pct = 9;
    run_traffic(240);

    // no idling; receiver holds off while the sender keeps offering
    set_timeout(16'($urandom_range(300, 1)));
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_asks++;
    run_traffic(240);

    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
